@@ hdl/bts_pkg.sv @@
// shared widths, codes and reset values of the bilinear texture sampler
package bts_pkg;

   localparam int COORD_W   = 32;
   localparam int ADDR_W    = 16;
   localparam int TEXEL_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int LOG2_W    = 4;
   localparam int SCALE_W   = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam int DEFAULT_MAX_SIZE_LOG2 = 8;

   // texel space position: fraction bits, and where the weight sits
   localparam int POS_FRAC_W = 24;
   localparam int WEIGHT_W   = 8;
   localparam int ONE_Q16    = 65536;

   localparam logic [LOG2_W-1:0]  RESET_WIDTH_LOG2  = 4'd8;
   localparam logic [LOG2_W-1:0]  RESET_HEIGHT_LOG2 = 4'd8;
   localparam logic [SCALE_W-1:0] RESET_SCALE_X     = 16'd256;
   localparam logic [SCALE_W-1:0] RESET_SCALE_Y     = 16'd256;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH_LOG2  = 2'd0,
      CSR_HEIGHT_LOG2 = 2'd1,
      CSR_SCALE_X     = 2'd2,
      CSR_SCALE_Y     = 2'd3
   } csr_index_type;

endpackage

@@ hdl/bts_if.sv @@
// request and response channel interfaces of the texture sampler
interface bts_req_if;
   import bts_pkg::*;

   logic                        valid;
   logic                        ready;
   op_type                      op;
   logic [ADDR_W-1:0]           texel_address;
   logic [TEXEL_W-1:0]          texel_value;
   logic signed [COORD_W-1:0]   coord_u;
   logic signed [COORD_W-1:0]   coord_v;

   modport source (output valid, output op, output texel_address, output texel_value,
                   output coord_u, output coord_v, input ready);
   modport sink   (input valid, input op, input texel_address, input texel_value,
                   input coord_u, input coord_v, output ready);
endinterface

interface bts_rsp_if;
   import bts_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   red;
   logic [CHAN_W-1:0]   green;
   logic [CHAN_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ hdl/bilinear_texture_sampler_top.sv @@
// bilinear texture sampler with repeat wrap, seven stage pipeline
//
// Takes one word per cycle and delivers one filtered sample per cycle while
// rsp_ch.ready holds; a texel write gives no response and leaves no sample.
// Stages: input register and v flip, coordinate by scale multiply, texel-space
// shift and wrap, texel addresses, texel memory read, horizontal blend,
// vertical blend into the output register. Any stage frees up as soon as its
// word moves on, so a waiting response stalls only the words behind it.
// The texel memory holds 2^(2*MAX_SIZE_LOG2) texels in two banks split on
// address bit 0, each with one write and two read ports, so the four
// neighbors of a sample are read in the same cycle. Writes land in program
// order with respect to sample reads. The memory is not cleared by reset;
// a texel reads back only after it has been written.
module bilinear_texture_sampler_top #(
   parameter int MAX_SIZE_LOG2 = bts_pkg::DEFAULT_MAX_SIZE_LOG2
) (
   input  logic                          clock,
   input  logic                          reset,
   bts_req_if.sink                       req_ch,
   bts_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_enable,
   input  bts_pkg::csr_index_type        csr_index,
   input  logic [bts_pkg::CSR_W-1:0]     csr_write_data
);
   import bts_pkg::*;

   localparam int DW         = 2 * MAX_SIZE_LOG2;
   localparam int BANK_DEPTH = 2 ** (DW - 1);
   localparam int PW         = POS_FRAC_W + MAX_SIZE_LOG2;
   localparam int VW         = COORD_W + 1;
   localparam int MW         = VW + SCALE_W + 1;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int ACC_W      = 3 * CHAN_W;
   localparam int GW         = WEIGHT_W + 1;
   localparam logic [LOG2_W-1:0] MAX_L = LOG2_W'(MAX_SIZE_LOG2);
   localparam logic [PW-1:0] HALF_TEXEL = PW'(1) << (POS_FRAC_W - 1);
   localparam logic [GW-1:0] WEIGHT_ONE = GW'(1) << WEIGHT_W;

   // configuration
   logic [LOG2_W-1:0]  width_log2_ff, height_log2_ff;
   logic [SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [LOG2_W-1:0]  wl, hl;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= RESET_WIDTH_LOG2;
         height_log2_ff <= RESET_HEIGHT_LOG2;
         scale_x_ff     <= RESET_SCALE_X;
         scale_y_ff     <= RESET_SCALE_Y;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WIDTH_LOG2:  width_log2_ff  <= csr_write_data[LOG2_W-1:0];
            CSR_HEIGHT_LOG2: height_log2_ff <= csr_write_data[LOG2_W-1:0];
            CSR_SCALE_X:     scale_x_ff     <= csr_write_data[SCALE_W-1:0];
            CSR_SCALE_Y:     scale_y_ff     <= csr_write_data[SCALE_W-1:0];
            default:         width_log2_ff  <= width_log2_ff;
         endcase
      end
   end

   assign wl = (width_log2_ff > MAX_L) ? MAX_L : width_log2_ff;
   assign hl = (height_log2_ff > MAX_L) ? MAX_L : height_log2_ff;

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic load1, load2, load3, load4, load5, load6, load7;

   assign load7 = !s7_valid_ff || rsp_ch.ready;
   assign load6 = !s6_valid_ff || load7;
   assign load5 = !s5_valid_ff || load6;
   assign load4 = !s4_valid_ff || load5;
   assign load3 = !s3_valid_ff || load4;
   assign load2 = !s2_valid_ff || load3;
   assign load1 = !s1_valid_ff || load2;

   assign req_ch.ready = load1;
   assign rsp_ch.valid = s7_valid_ff;

   // stage payloads
   op_type                  s1_op_ff, s2_op_ff, s3_op_ff, s4_op_ff;
   logic [DW-1:0]           s1_addr_ff, s2_addr_ff, s3_addr_ff, s4_addr_ff;
   logic [TEXEL_W-1:0]      s1_value_ff, s2_value_ff, s3_value_ff, s4_value_ff;
   logic signed [COORD_W-1:0] s1_u_ff;
   logic signed [VW-1:0]    s1_v_ff, s1_v_in;
   logic signed [MW-1:0]    mul_u, mul_v;
   logic [PW-1:0]           s2_px_ff, s2_py_ff;
   logic [PW-1:0]           sx, sy;
   logic [MAX_SIZE_LOG2-1:0] wmask, hmask;
   logic [MAX_SIZE_LOG2-1:0] x1_in, x2_in, y1_in, y2_in;
   logic [MAX_SIZE_LOG2-1:0] s3_x1_ff, s3_x2_ff, s3_y1_ff, s3_y2_ff;
   logic [WEIGHT_W-1:0]     s3_fx_ff, s3_fy_ff, s4_fx_ff, s4_fy_ff, s5_fx_ff, s5_fy_ff;
   logic [WEIGHT_W-1:0]     s6_fy_ff;
   logic [DW-1:0]           s4_a00_ff, s4_a10_ff, s4_a01_ff, s4_a11_ff;
   logic [3:0]              s5_sel_ff;

   assign s1_v_in = VW'(ONE_Q16) - VW'(req_ch.coord_v);

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_op_ff    <= req_ch.op;
         s1_addr_ff  <= DW'(req_ch.texel_address);
         s1_value_ff <= req_ch.texel_value;
         s1_u_ff     <= req_ch.coord_u;
         s1_v_ff     <= s1_v_in;
      end
   end

   assign mul_u = MW'(s1_u_ff) * MW'($signed({1'b0, scale_x_ff}));
   assign mul_v = MW'(s1_v_ff) * MW'($signed({1'b0, scale_y_ff}));

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_op_ff    <= s1_op_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_value_ff <= s1_value_ff;
         s2_px_ff    <= mul_u[PW-1:0];
         s2_py_ff    <= mul_v[PW-1:0];
      end
   end

   // texel space, repeat wrap
   always_comb begin
      sx    = (s2_px_ff << wl) - HALF_TEXEL;
      sy    = (s2_py_ff << hl) - HALF_TEXEL;
      wmask = ~({MAX_SIZE_LOG2{1'b1}} << wl);
      hmask = ~({MAX_SIZE_LOG2{1'b1}} << hl);
      x1_in = sx[POS_FRAC_W +: MAX_SIZE_LOG2] & wmask;
      y1_in = sy[POS_FRAC_W +: MAX_SIZE_LOG2] & hmask;
      x2_in = (x1_in + MAX_SIZE_LOG2'(1)) & wmask;
      y2_in = (y1_in + MAX_SIZE_LOG2'(1)) & hmask;
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_op_ff    <= s2_op_ff;
         s3_addr_ff  <= s2_addr_ff;
         s3_value_ff <= s2_value_ff;
         s3_x1_ff    <= x1_in;
         s3_x2_ff    <= x2_in;
         s3_y1_ff    <= y1_in;
         s3_y2_ff    <= y2_in;
         s3_fx_ff    <= sx[POS_FRAC_W-1 -: WEIGHT_W];
         s3_fy_ff    <= sy[POS_FRAC_W-1 -: WEIGHT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load4) begin
         s4_op_ff    <= s3_op_ff;
         s4_addr_ff  <= s3_addr_ff;
         s4_value_ff <= s3_value_ff;
         s4_fx_ff    <= s3_fx_ff;
         s4_fy_ff    <= s3_fy_ff;
         s4_a00_ff   <= DW'(s3_x1_ff) + (DW'(s3_y1_ff) << wl);
         s4_a10_ff   <= DW'(s3_x2_ff) + (DW'(s3_y1_ff) << wl);
         s4_a01_ff   <= DW'(s3_x1_ff) + (DW'(s3_y2_ff) << wl);
         s4_a11_ff   <= DW'(s3_x2_ff) + (DW'(s3_y2_ff) << wl);
      end
   end

   // texel memory, banked on address bit 0
   logic [TEXEL_W-1:0] bank0_mem [BANK_DEPTH];
   logic [TEXEL_W-1:0] bank1_mem [BANK_DEPTH];
   logic [TEXEL_W-1:0] rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;
   logic [DW-2:0]      b0_addr_a, b0_addr_b, b1_addr_a, b1_addr_b, widx;
   logic               wr_en;

   // port a serves the upper row, port b the lower row
   assign b0_addr_a = s4_a00_ff[0] ? s4_a10_ff[DW-1:1] : s4_a00_ff[DW-1:1];
   assign b1_addr_a = s4_a00_ff[0] ? s4_a00_ff[DW-1:1] : s4_a10_ff[DW-1:1];
   assign b0_addr_b = s4_a01_ff[0] ? s4_a11_ff[DW-1:1] : s4_a01_ff[DW-1:1];
   assign b1_addr_b = s4_a01_ff[0] ? s4_a01_ff[DW-1:1] : s4_a11_ff[DW-1:1];
   assign widx      = s4_addr_ff[DW-1:1];
   assign wr_en     = load5 && s4_valid_ff && (s4_op_ff == OP_WRITE);

   always_ff @(posedge clock) begin
      if (wr_en && !s4_addr_ff[0]) begin
         bank0_mem[widx] <= s4_value_ff;
      end
      if (load5) begin
         rd0a_ff <= bank0_mem[b0_addr_a];
         rd0b_ff <= bank0_mem[b0_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && s4_addr_ff[0]) begin
         bank1_mem[widx] <= s4_value_ff;
      end
      if (load5) begin
         rd1a_ff <= bank1_mem[b1_addr_a];
         rd1b_ff <= bank1_mem[b1_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (load5) begin
         s5_fx_ff  <= s4_fx_ff;
         s5_fy_ff  <= s4_fy_ff;
         s5_sel_ff <= {s4_a11_ff[0], s4_a01_ff[0], s4_a10_ff[0], s4_a00_ff[0]};
      end
   end

   // horizontal blend
   logic [TEXEL_W-1:0] t00, t10, t01, t11;
   logic [GW-1:0]      gx, gy;
   logic [PROD_W-1:0]  top_in [NUM_CHAN];
   logic [PROD_W-1:0]  bot_in [NUM_CHAN];
   logic [PROD_W-1:0]  s6_top_ff [NUM_CHAN];
   logic [PROD_W-1:0]  s6_bot_ff [NUM_CHAN];
   logic [ACC_W-1:0]   acc [NUM_CHAN];
   logic [CHAN_W-1:0]  s7_chan_ff [NUM_CHAN];

   assign t00 = s5_sel_ff[0] ? rd1a_ff : rd0a_ff;
   assign t10 = s5_sel_ff[1] ? rd1a_ff : rd0a_ff;
   assign t01 = s5_sel_ff[2] ? rd1b_ff : rd0b_ff;
   assign t11 = s5_sel_ff[3] ? rd1b_ff : rd0b_ff;
   assign gx  = WEIGHT_ONE - GW'(s5_fx_ff);

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         top_in[k] = PROD_W'(t00[CHAN_W*k +: CHAN_W]) * PROD_W'(gx)
                   + PROD_W'(t10[CHAN_W*k +: CHAN_W]) * PROD_W'(s5_fx_ff);
         bot_in[k] = PROD_W'(t01[CHAN_W*k +: CHAN_W]) * PROD_W'(gx)
                   + PROD_W'(t11[CHAN_W*k +: CHAN_W]) * PROD_W'(s5_fx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load6) begin
         s6_top_ff <= top_in;
         s6_bot_ff <= bot_in;
         s6_fy_ff  <= s5_fy_ff;
      end
   end

   // vertical blend
   assign gy = WEIGHT_ONE - GW'(s6_fy_ff);

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         acc[k] = ACC_W'(s6_top_ff[k]) * ACC_W'(gy) + ACC_W'(s6_bot_ff[k]) * ACC_W'(s6_fy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load7) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            s7_chan_ff[k] <= acc[k][ACC_W-1 -: CHAN_W];
         end
      end
   end

   assign rsp_ch.blue  = s7_chan_ff[0];
   assign rsp_ch.green = s7_chan_ff[1];
   assign rsp_ch.red   = s7_chan_ff[2];

   // valid bits, write words drop out after the memory stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (load1) s1_valid_ff <= req_ch.valid;
         if (load2) s2_valid_ff <= s1_valid_ff;
         if (load3) s3_valid_ff <= s2_valid_ff;
         if (load4) s4_valid_ff <= s3_valid_ff;
         if (load5) s5_valid_ff <= s4_valid_ff && (s4_op_ff == OP_SAMPLE);
         if (load6) s6_valid_ff <= s5_valid_ff;
         if (load7) s7_valid_ff <= s6_valid_ff;
      end
   end

endmodule
